/* hw/rtl/lca_pkg.sv */
// ----------------------------------------------------------------------------
// Lowest common ancestor package
// Shared node width, table depth, request codes and controller state codes.
// ----------------------------------------------------------------------------
package lca_pkg;

	localparam int NODE_W      = 10;
	localparam int TABLE_DEPTH = 1 << NODE_W;

	typedef logic [NODE_W-1:0] node_t;

	// Request codes carried on req_type.
	localparam logic REQ_SET   = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Controller states, one-hot.
	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_MARK   = 5'b00100,
		ST_FIND   = 5'b01000,
		ST_UNMARK = 5'b10000
	} state_t;

endpackage

/* hw/rtl/lowest_common_ancestor.sv */
// ----------------------------------------------------------------------------
// Lowest common ancestor over a parent-pointer table
// Set beats store a parent pointer; query beats walk two ancestor chains.
// ----------------------------------------------------------------------------
// A set beat gives no result; sets may follow back to back. A query marks the node_b
// chain, checks the node_a chain up to the first marked node or the walk end, and
// unmarks the node_b chain; done strobes its result in the cycle after the unmark walk
// ends. After reset the block runs a clearing pass over every entry with busy high.
// The receiver cannot stall: done is high for a single cycle; ancestor and found are
// held until the next query ends its find walk.
// ----------------------------------------------------------------------------
module lowest_common_ancestor
	import lca_pkg::*;
#(
	parameter int MAX_NODES = 1023
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              req_type,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	output logic              done,
	output logic [NODE_W-1:0] ancestor,
	output logic              found
);

	// The step counter must hold MAX_NODES itself, the cap of every walk.
	localparam int STEP_W = $clog2(MAX_NODES + 1);
	localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(MAX_NODES);
	localparam logic [16:0] NODE_LIMIT = 17'(MAX_NODES);

	// Both stores live in synchronous memories that share one read address.
	// The parent table holds the parent of every node, the mark memory one
	// bit per node that flags the ancestor chain of node_b during a query.
	node_t parent_mem [TABLE_DEPTH];
	logic  mark_mem   [TABLE_DEPTH];

	state_t state_q, state_d;

	node_t             cur_q;      // node whose memory words are read out now
	node_t             a_q;        // first query node
	node_t             b_q;        // second query node
	logic [STEP_W-1:0] steps_q;    // nodes visited so far on this walk
	node_t             clr_idx_q;  // clearing pass pointer

	node_t parent_rd_q;            // registered read data of the parent table
	logic  mark_rd_q;              // registered read data of the mark memory

	node_t ancestor_q;
	logic  found_q;
	logic  done_q;

	node_t rd_addr;
	logic  ptab_we;
	node_t ptab_wa;
	node_t ptab_wd;
	logic  mark_we;
	node_t mark_wa;
	logic  mark_wd;

	logic  cur_is_node;
	logic  walk_end;
	logic  hit;
	logic  accept;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// A walk stops at a number that is not a node (zero or above the limit)
	// and after MAX_NODES visited nodes, which also breaks any cycle.
	assign cur_is_node = (cur_q != '0) && ({7'd0, cur_q} <= NODE_LIMIT);
	assign walk_end    = !cur_is_node || (steps_q == STEP_MAX);
	assign hit         = (state_q == ST_FIND) && !walk_end && mark_rd_q;

	// Next state and the single read address. In a walk the next address is
	// simply the parent just read, so each cycle advances one node.
	always_comb begin
		state_d = state_q;
		rd_addr = parent_rd_q;
		unique case (state_q)
			ST_CLEAR: begin
				rd_addr = clr_idx_q;
				if (clr_idx_q == node_t'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				rd_addr = node_b;
				if (accept && req_type == REQ_QUERY) begin
					state_d = ST_MARK;
				end
			end
			ST_MARK: begin
				if (walk_end) begin
					rd_addr = a_q;
					state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (walk_end || hit) begin
					rd_addr = b_q;
					state_d = ST_UNMARK;
				end
			end
			ST_UNMARK: begin
				if (walk_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Write ports. The clearing pass zeroes both memories. A set beat on a
	// real node writes the parent table. The mark walk sets marks along the
	// node_b chain and the unmark walk retraces the very same chain to clear
	// them again, so no full sweep is needed between queries.
	always_comb begin
		ptab_we = 1'b0;
		ptab_wa = node_a;
		ptab_wd = node_b;
		mark_we = 1'b0;
		mark_wa = cur_q;
		mark_wd = 1'b0;
		priority if (state_q == ST_CLEAR) begin
			ptab_we = 1'b1;
			ptab_wa = clr_idx_q;
			ptab_wd = '0;
			mark_we = 1'b1;
			mark_wa = clr_idx_q;
		end else if (accept && req_type == REQ_SET) begin
			ptab_we = (node_a != '0) && ({7'd0, node_a} <= NODE_LIMIT);
		end else if (state_q == ST_MARK) begin
			mark_we = !walk_end;
			mark_wd = 1'b1;
		end else if (state_q == ST_UNMARK) begin
			mark_we = !walk_end;
		end else begin
			// Idle cycles and the find walk write nothing.
		end
	end

	always_ff @(posedge clk) begin
		if (ptab_we) begin
			parent_mem[ptab_wa] <= ptab_wd;
		end
		parent_rd_q <= parent_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (mark_we) begin
			mark_mem[mark_wa] <= mark_wd;
		end
		mark_rd_q <= mark_mem[rd_addr];
	end

	// The current node always follows the read address, so the memory words
	// seen in a cycle belong to cur_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			steps_q   <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_UNMARK) && walk_end;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + node_t'(1);
			end
			if (state_d != state_q) begin
				steps_q <= '0;
			end else if (state_q == ST_MARK || state_q == ST_FIND
			             || state_q == ST_UNMARK) begin
				steps_q <= steps_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= rd_addr;
		if (accept) begin
			a_q <= node_a;
			b_q <= node_b;
		end
		// The answer is settled when the find walk ends, by a hit or not.
		if (state_q == ST_FIND && (walk_end || hit)) begin
			ancestor_q <= hit ? cur_q : '0;
			found_q    <= hit;
		end
	end

	assign done     = done_q;
	assign ancestor = ancestor_q;
	assign found    = found_q;

	// A result beat is a lone one-cycle strobe.
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A miss always reports node zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(done && !found) |-> (ancestor == '0))
		else $error("miss reported with a nonzero ancestor");

	// An accepted query makes the block busy on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type == REQ_QUERY) |=> busy)
		else $error("query accepted but block not busy");

	// No walk visits more than MAX_NODES nodes.
	assert property (@(posedge clk) disable iff (!arst_n) steps_q <= STEP_MAX)
		else $error("walk step count above the cap");

endmodule
